// ===== design/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and codes for the positional array list: request and result
// items, operation and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic signed [31:0] ERR_DATA = -32'sd1;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         position;
      logic signed [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic [7:0]         moves;
      logic [7:0]         length;
      logic               is_empty_flag;
      logic               is_full_flag;
   } rsp_item_type;

   typedef struct packed {
      logic        ins_en;
      logic        del_en;
      logic [7:0]  position;
      logic [31:0] value;
   } cell_ctrl_type;

endpackage

// ===== design/plt_cell.sv =====
// ----------------------------------------------------------------------------
// plt_cell
// One list entry. On insert it takes its lower neighbor's entry or the new
// value; on delete it takes its upper neighbor's entry. It also drives its
// entry onto the read port when the requested position matches its index.
// ----------------------------------------------------------------------------
module plt_cell
   import plt_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    cell_index,
   input  logic [31:0]   left_data,
   input  logic [31:0]   right_data,
   output logic [31:0]   data_out,
   output logic [31:0]   rd_data
);

   logic [31:0] entry_ff;
   logic [31:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (cell_index == ctrl.position) begin
            entry_in = ctrl.value;
         end else if (cell_index > ctrl.position) begin
            entry_in = left_data;
         end
      end else if (ctrl.del_en) begin
         if (cell_index >= ctrl.position) begin
            entry_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_out = entry_ff;
   assign rd_data  = (cell_index == ctrl.position) ? entry_ff : '0;

endmodule

// ===== design/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list of signed 32-bit values held in a row of entry cells.
// ----------------------------------------------------------------------------
// The list keeps one cell per entry, and every cell shifts in parallel, so an
// insert or delete at any position updates all cells at once regardless of
// how many entries move. An item passes through three steps inside the block:
// the update stage decides the status and updates the cells and the length,
// the read stage collects the addressed entry through a registered OR tree
// over groups of cells, and the result register holds the result. Only one
// item is in the update or read stage at a time, so a new item is taken only
// once the previous one has left the read stage; a stalled result holds it
// there. Entries are not cleared at reset and a clear only resets the length.
module positional_array_list
   import plt_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int GROUP = 16;
   localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;
   localparam logic [7:0] CAP8 = 8'(CAPACITY);

   logic         accept;
   logic         b_move;
   logic         a_vld_ff, a_vld_in;
   logic         b_vld_ff, b_vld_in;
   logic         rsp_vld_ff, rsp_vld_in;
   req_item_type a_item_ff;
   logic [7:0]   count_ff, count_in;

   logic [1:0]   status_c;
   logic [7:0]   moves_c;
   logic         ok_c;

   logic [1:0]   b_status_ff;
   logic [1:0]   b_op_ff;
   logic [7:0]   b_moves_ff;
   logic [7:0]   b_len_ff;
   logic [31:0]  grp_ff [NGRP];
   logic [31:0]  grp_or [NGRP];
   logic [31:0]  read_or;
   rsp_item_type rsp_item_ff;

   cell_ctrl_type ctrl;
   logic [31:0]   cell_q  [CAPACITY];
   logic [31:0]   cell_rd [CAPACITY];

   assign req_stall = a_vld_ff | b_vld_ff;
   assign accept    = req_valid & ~req_stall;
   assign b_move    = b_vld_ff & (~rsp_vld_ff | ~rsp_stall);

   always_comb begin
      status_c = STATUS_OK;
      moves_c  = '0;
      count_in = count_ff;
      unique case (a_item_ff.req_type)
         OP_INSERT: begin
            if (count_ff >= CAP8) begin
               status_c = STATUS_FULL;
            end else if (a_item_ff.position > count_ff) begin
               status_c = STATUS_RANGE;
            end else begin
               moves_c  = count_ff - a_item_ff.position;
               count_in = count_ff + 8'd1;
            end
         end
         OP_DELETE: begin
            if (a_item_ff.position >= count_ff) begin
               status_c = STATUS_RANGE;
            end else begin
               moves_c  = count_ff - a_item_ff.position - 8'd1;
               count_in = count_ff - 8'd1;
            end
         end
         OP_READ: begin
            if (a_item_ff.position >= count_ff) begin
               status_c = STATUS_RANGE;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status_c = STATUS_OK;
         end
      endcase
      ok_c = (status_c == STATUS_OK);
   end

   always_comb begin
      ctrl.ins_en   = a_vld_ff & ok_c & (a_item_ff.req_type == OP_INSERT);
      ctrl.del_en   = a_vld_ff & ok_c & (a_item_ff.req_type == OP_DELETE);
      ctrl.position = a_item_ff.position;
      ctrl.value    = a_item_ff.value;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [31:0] left_w;
      logic [31:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid
         assign left_w = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = cell_q[i];
      end else begin : g_inner
         assign right_w = cell_q[i+1];
      end
      plt_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (8'(i)),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_q[i]),
         .rd_data    (cell_rd[i])
      );
   end

   for (genvar g = 0; g < NGRP; g++) begin : g_grp
      localparam int BASE  = g * GROUP;
      localparam int GSIZE = (CAPACITY - BASE < GROUP) ? (CAPACITY - BASE) : GROUP;
      always_comb begin
         grp_or[g] = '0;
         for (int j = 0; j < GSIZE; j++) begin
            grp_or[g] = grp_or[g] | cell_rd[BASE + j];
         end
      end
      always_ff @(posedge clock) begin
         if (a_vld_ff) begin
            grp_ff[g] <= grp_or[g];
         end
      end
   end

   always_comb begin
      read_or = '0;
      for (int g = 0; g < NGRP; g++) begin
         read_or = read_or | grp_ff[g];
      end
   end

   assign a_vld_in   = accept | (a_vld_ff & 1'b0);
   assign b_vld_in   = a_vld_ff | (b_vld_ff & ~b_move);
   assign rsp_vld_in = b_move | (rsp_vld_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (a_vld_ff) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_item_ff <= req_item;
      end
      if (a_vld_ff) begin
         b_status_ff <= status_c;
         b_op_ff     <= a_item_ff.req_type;
         b_moves_ff  <= moves_c;
         b_len_ff    <= count_in;
      end
      if (b_move) begin
         rsp_item_ff.status <= b_status_ff;
         rsp_item_ff.data_out <= ((b_status_ff == STATUS_OK) &&
                                  ((b_op_ff == OP_DELETE) || (b_op_ff == OP_READ)))
                                 ? read_or : ERR_DATA;
         rsp_item_ff.moves         <= b_moves_ff;
         rsp_item_ff.length        <= b_len_ff;
         rsp_item_ff.is_empty_flag <= (b_len_ff == 8'd0);
         rsp_item_ff.is_full_flag  <= (b_len_ff >= CAP8);
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_item_ff;

   a_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> a_vld_ff)
      else $error("accepted item did not enter the update stage");

   b_follows_a: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff |=> b_vld_ff)
      else $error("update stage did not pass its item to the read stage");

   one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(a_vld_ff && b_vld_ff))
      else $error("two items inside the block at once");

   count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP8)
      else $error("list length exceeds capacity");

   count_only_on_update: assert property (@(posedge clock) disable iff (reset)
      !$past(a_vld_ff) |-> $stable(count_ff))
      else $error("list length changed without an item in the update stage");

endmodule
